[sv/bandpass_biquad_filter_bank_unit_assert.svh]
// assertion macros for the band-pass biquad bank checker
// no dependencies; included by files that carry concurrent assertions
`ifndef BANDPASS_BIQUAD_FILTER_BANK_UNIT_ASSERT_SVH
`define BANDPASS_BIQUAD_FILTER_BANK_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BBF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbf assertion failed");

// next-cycle implication, disabled while reset is low
`define BBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbf assertion failed");

`endif

[sv/bbf_pkg.sv]
// shared types and constants of the band-pass biquad bank
// no dependencies; used by the top level, the datapath and the checker
package bbf_pkg;

    localparam int BANDS_DEFAULT   = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 20;
    localparam int COEF_FRAC       = COEF_BITS - 4;
    localparam int BAND_FIELD_BITS = 4;
    localparam int NUM_BANDS_BITS  = 5;
    localparam int SEL_BITS        = 2;

    // operation codes
    localparam logic OP_SAMPLE     = 1'b0;
    localparam logic OP_COEF_WRITE = 1'b1;

    // coefficient select codes
    localparam logic [SEL_BITS-1:0] SEL_B0 = 2'd0;
    localparam logic [SEL_BITS-1:0] SEL_A1 = 2'd1;
    localparam logic [SEL_BITS-1:0] SEL_A2 = 2'd2;

    localparam logic [NUM_BANDS_BITS-1:0] NUM_BANDS_RESET = 5'd16;

    typedef struct packed {
        logic                          operation;
        logic [BAND_FIELD_BITS-1:0]    band;
        logic [SEL_BITS-1:0]           coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [BAND_FIELD_BITS-1:0]    out_band;
        logic signed [SAMPLE_BITS-1:0] band_sample;
        logic                          clipped;
        logic                          last;
    } out_item_t;

    // control that travels with a band through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctrl_t;

    // control captured at issue: which memory words are still at reset value
    typedef struct packed {
        logic valid;
        logic last;
        logic coef_ok;
        logic hist_ok;
    } issue_t;

    // history write-back from the arithmetic pipeline
    typedef struct packed {
        logic                          en;
        logic signed [SAMPLE_BITS-1:0] y_new;
        logic signed [SAMPLE_BITS-1:0] y_old;
    } hist_wb_t;

endpackage

[sv/bandpass_biquad_filter_bank_unit.sv]
// top level of the band-pass biquad filter bank: sequencer, delay line, memories
// depends on bbf_pkg, bbf_ram, bbf_datapath
//
// A bank of up to BANDS band-pass biquads in direct form I, with numerator
// b0, 0, -b0 and denominator 1, a1, a2. All bands share the two previous input
// samples; each band keeps its own two previous saturated outputs. A sample
// request yields one result per active band (num_bands, clamped to 1..BANDS),
// in band order, the final one flagged by last. A coefficient request loads
// b0, a1 or a2 of one band and yields nothing; an unused select or a band
// beyond the bank is dropped. Coefficients are Q3.16, samples Q1.15; the three
// products are summed exactly, rounded half up and saturated. Timing: one band
// is issued per cycle from the coefficient and history memories (one read
// port each) while the result side does not stall; the next request is taken
// only once every band of a sample has left the pipeline. A coefficient request
// is read, merged and written back before the next request is taken. Result
// backpressure freezes the whole pipeline. Memories need no clearing pass:
// per-band valid bits make unwritten entries read as zero right after reset.
// The num_bands register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module bandpass_biquad_filter_bank_unit #(
    parameter int BANDS = bbf_pkg::BANDS_DEFAULT,
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bbf_pkg::NUM_BANDS_BITS-1:0]    cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bbf_pkg::in_item_t                     s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bbf_pkg::out_item_t                    m_item
);

    localparam int SB     = bbf_pkg::SAMPLE_BITS;
    localparam int CB     = bbf_pkg::COEF_BITS;
    localparam int DIFF_W = SB + 1;
    localparam int CW_W   = 3 * CB;
    localparam int HW_W   = 2 * SB;
    localparam int CNT_W  = $clog2(BANDS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COEF
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration and shared input history
    logic [bbf_pkg::NUM_BANDS_BITS-1:0] num_bands_reg;
    logic signed [SB-1:0]               xd1_reg;
    logic signed [SB-1:0]               xd2_reg;
    logic signed [DIFF_W-1:0]           diff_reg;

    // sequencer
    logic [BAND_W-1:0]  band_cnt_reg;
    logic [BAND_W-1:0]  last_idx_reg;
    logic [BAND_W-1:0]  last_idx_calc;
    logic [CNT_W-1:0]   active_cnt;
    bbf_pkg::issue_t    p1_reg;
    bbf_pkg::issue_t    p1_next;
    logic               issue;

    // per-band valid bits: an entry not yet written reads as zero
    logic [BANDS-1:0]   coef_vld_reg;
    logic [BANDS-1:0]   hist_vld_reg;

    // coefficient write held over the read-modify-write
    logic [BAND_W-1:0]              wr_band_reg;
    logic [bbf_pkg::SEL_BITS-1:0]   wr_sel_reg;
    logic signed [CB-1:0]           wr_val_reg;

    logic               s_fire;
    logic               coef_req_ok;

    // memory ports
    logic               coef_rd_en;
    logic [BAND_W-1:0]  coef_rd_addr;
    logic [CW_W-1:0]    coef_rd_data;
    logic               coef_wr_en;
    logic [CW_W-1:0]    coef_cur;
    logic [CW_W-1:0]    coef_wr_data;
    logic [HW_W-1:0]    hist_rd_data;
    logic [HW_W-1:0]    hist_wr_data;

    // datapath side
    logic                     dp_advance;
    logic                     dp_busy;
    bbf_pkg::pipe_ctrl_t      dp_ctrl;
    logic [BAND_W-1:0]        dp_band_reg;
    logic signed [CB-1:0]     b0_m;
    logic signed [CB-1:0]     a1_m;
    logic signed [CB-1:0]     a2_m;
    logic signed [SB-1:0]     y1_m;
    logic signed [SB-1:0]     y2_m;
    bbf_pkg::hist_wb_t        wb;
    logic [BAND_W-1:0]        wb_band;

    assign cfg_ready = 1'b1;

    // a new request only once every band of the previous one has left the pipe
    assign s_ready = (state_reg == ST_IDLE) && !p1_reg.valid && !dp_busy;
    assign s_fire  = s_valid && s_ready;

    assign coef_req_ok = (32'(s_item.band) < BANDS) &&
                         ((s_item.coef_select == bbf_pkg::SEL_B0) ||
                          (s_item.coef_select == bbf_pkg::SEL_A1) ||
                          (s_item.coef_select == bbf_pkg::SEL_A2));

    // clamp of num_bands to 1..BANDS, as the index of the last band
    always_comb begin
        if (num_bands_reg == '0) begin
            active_cnt = CNT_W'(1);
        end else if (32'(num_bands_reg) > BANDS) begin
            active_cnt = CNT_W'(BANDS);
        end else begin
            active_cnt = CNT_W'(num_bands_reg);
        end
        last_idx_calc = BAND_W'(active_cnt - CNT_W'(1));
    end

    // one band issued per cycle while running and the pipe moves
    assign issue = (state_reg == ST_RUN) && dp_advance;

    always_comb begin
        p1_next = p1_reg;
        if (dp_advance) begin
            p1_next.valid   = issue;
            p1_next.last    = (band_cnt_reg == last_idx_reg);
            p1_next.coef_ok = coef_vld_reg[band_cnt_reg];
            p1_next.hist_ok = hist_vld_reg[band_cnt_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_item.operation == bbf_pkg::OP_SAMPLE) begin
                        state_next = ST_RUN;
                    end else if (coef_req_ok) begin
                        state_next = ST_COEF;
                    end
                end
            end
            ST_RUN: begin
                if (dp_advance && (band_cnt_reg == last_idx_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_COEF: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // coefficient memory: read for issue or for the merge of a write
    assign coef_rd_en   = issue || (s_fire && (s_item.operation == bbf_pkg::OP_COEF_WRITE)
                                    && coef_req_ok);
    assign coef_rd_addr = (state_reg == ST_RUN) ? band_cnt_reg : BAND_W'(s_item.band);
    assign coef_wr_en   = (state_reg == ST_COEF);
    assign coef_cur     = coef_vld_reg[wr_band_reg] ? coef_rd_data : '0;

    always_comb begin
        coef_wr_data = coef_cur;
        unique case (wr_sel_reg)
            bbf_pkg::SEL_B0: coef_wr_data[3*CB-1:2*CB] = wr_val_reg;
            bbf_pkg::SEL_A1: coef_wr_data[2*CB-1:CB]   = wr_val_reg;
            bbf_pkg::SEL_A2: coef_wr_data[CB-1:0]      = wr_val_reg;
            default:         coef_wr_data = coef_cur;
        endcase
    end

    // words still at reset value read as zero
    assign b0_m = p1_reg.coef_ok ? signed'(coef_rd_data[3*CB-1:2*CB]) : '0;
    assign a1_m = p1_reg.coef_ok ? signed'(coef_rd_data[2*CB-1:CB])   : '0;
    assign a2_m = p1_reg.coef_ok ? signed'(coef_rd_data[CB-1:0])      : '0;
    assign y1_m = p1_reg.hist_ok ? signed'(hist_rd_data[2*SB-1:SB])   : '0;
    assign y2_m = p1_reg.hist_ok ? signed'(hist_rd_data[SB-1:0])      : '0;

    assign dp_ctrl.valid = p1_reg.valid;
    assign dp_ctrl.last  = p1_reg.last;

    // new history word: {y[n], y[n-1]}
    assign hist_wr_data = {wb.y_new, wb.y_old};

    // control state, valid bits and the shared input history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            num_bands_reg <= bbf_pkg::NUM_BANDS_RESET;
            xd1_reg       <= '0;
            xd2_reg       <= '0;
            coef_vld_reg  <= '0;
            hist_vld_reg  <= '0;
            p1_reg        <= '0;
            band_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            p1_reg    <= p1_next;
            if (cfg_valid && cfg_ready) begin
                num_bands_reg <= cfg_data;
            end
            if (s_fire && (s_item.operation == bbf_pkg::OP_SAMPLE)) begin
                xd2_reg      <= xd1_reg;
                xd1_reg      <= s_item.sample;
                band_cnt_reg <= '0;
            end else if (issue) begin
                band_cnt_reg <= band_cnt_reg + BAND_W'(1);
            end
            if (coef_wr_en) begin
                coef_vld_reg[wr_band_reg] <= 1'b1;
            end
            if (wb.en) begin
                hist_vld_reg[wb_band] <= 1'b1;
            end
        end
    end

    // request payload held for the duration of the request
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            diff_reg     <= DIFF_W'(s_item.sample) - DIFF_W'(xd2_reg);
            last_idx_reg <= last_idx_calc;
            wr_band_reg  <= BAND_W'(s_item.band);
            wr_sel_reg   <= s_item.coef_select;
            wr_val_reg   <= s_item.coef_value;
        end
        if (issue) begin
            dp_band_reg <= band_cnt_reg;
        end
    end

    bbf_ram #(
        .WIDTH (CW_W),
        .DEPTH (BANDS)
    ) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (coef_wr_en),
        .wr_addr (wr_band_reg),
        .wr_data (coef_wr_data),
        .rd_en   (coef_rd_en),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd_data)
    );

    bbf_ram #(
        .WIDTH (HW_W),
        .DEPTH (BANDS)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (wb.en),
        .wr_addr (wb_band),
        .wr_data (hist_wr_data),
        .rd_en   (issue),
        .rd_addr (band_cnt_reg),
        .rd_data (hist_rd_data)
    );

    bbf_datapath #(
        .BANDS (BANDS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (dp_advance),
        .busy     (dp_busy),
        .in_ctrl  (dp_ctrl),
        .in_band  (dp_band_reg),
        .diff     (diff_reg),
        .b0       (b0_m),
        .a1       (a1_m),
        .a2       (a2_m),
        .y1       (y1_m),
        .y2       (y2_m),
        .wb       (wb),
        .wb_band  (wb_band),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

[sv/bbf_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bbf_datapath.sv]
// multiply, accumulate, round and saturate pipeline with output register
// depends on bbf_pkg
module bbf_datapath #(
    parameter int BANDS = bbf_pkg::BANDS_DEFAULT,
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    output logic                                    advance,
    output logic                                    busy,
    input  bbf_pkg::pipe_ctrl_t                     in_ctrl,
    input  logic [BAND_W-1:0]                       in_band,
    input  logic signed [bbf_pkg::SAMPLE_BITS:0]    diff,
    input  logic signed [bbf_pkg::COEF_BITS-1:0]    b0,
    input  logic signed [bbf_pkg::COEF_BITS-1:0]    a1,
    input  logic signed [bbf_pkg::COEF_BITS-1:0]    a2,
    input  logic signed [bbf_pkg::SAMPLE_BITS-1:0]  y1,
    input  logic signed [bbf_pkg::SAMPLE_BITS-1:0]  y2,
    output bbf_pkg::hist_wb_t                       wb,
    output logic [BAND_W-1:0]                       wb_band,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output bbf_pkg::out_item_t                      m_item
);

    localparam int SB     = bbf_pkg::SAMPLE_BITS;
    localparam int CB     = bbf_pkg::COEF_BITS;
    localparam int FRAC   = bbf_pkg::COEF_FRAC;
    localparam int BF     = bbf_pkg::BAND_FIELD_BITS;
    localparam int ACC_W  = SB + CB + 2;
    localparam int Q_W    = ACC_W - FRAC;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

    logic signed [SB+CB:0]   prod_gain;
    logic signed [SB+CB-1:0] prod_fb1;
    logic signed [SB+CB-1:0] prod_fb2;

    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic [BAND_W-1:0]       a_band_reg;
    logic signed [SB+CB:0]   a_gain_reg;
    logic signed [SB+CB-1:0] a_fb1_reg;
    logic signed [SB+CB-1:0] a_fb2_reg;
    logic signed [SB-1:0]    a_y1_reg;

    logic                    m_valid_reg;
    bbf_pkg::out_item_t      m_item_reg;
    bbf_pkg::out_item_t      result;

    logic signed [ACC_W-1:0] acc;
    logic [Q_W-1:0]          q;
    logic [Q_W-SB:0]         q_top;
    logic                    fits;
    logic signed [SB-1:0]    y_sat;

    assign advance = !m_valid_reg || m_ready;
    assign busy    = a_valid_reg;

    // stage one: three products
    assign prod_gain = diff * b0;
    assign prod_fb1  = y1 * a1;
    assign prod_fb2  = y2 * a2;

    // stage two: sum, round half up, saturate
    assign acc   = ACC_W'(a_gain_reg) - ACC_W'(a_fb1_reg) - ACC_W'(a_fb2_reg) + HALF;
    assign q     = acc[ACC_W-1:FRAC];
    assign q_top = q[Q_W-1:SB-1];
    assign fits  = (&q_top) || !(|q_top);
    assign y_sat = fits ? signed'(q[SB-1:0]) : (q[Q_W-1] ? SMIN : SMAX);

    always_comb begin
        result.out_band    = BF'(a_band_reg);
        result.band_sample = y_sat;
        result.clipped     = !fits;
        result.last        = a_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_ctrl.valid;
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_last_reg <= in_ctrl.last;
            a_band_reg <= in_band;
            a_gain_reg <= prod_gain;
            a_fb1_reg  <= prod_fb1;
            a_fb2_reg  <= prod_fb2;
            a_y1_reg   <= y1;
            m_item_reg <= result;
        end
    end

    // history is written as the result enters the output register
    always_comb begin
        wb.en    = advance && a_valid_reg;
        wb.y_new = y_sat;
        wb.y_old = a_y1_reg;
    end
    assign wb_band = a_band_reg;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[sv/bbf_checker.sv]
// port-level checker for the band-pass biquad bank, bound to the top level
// depends on bbf_pkg and bandpass_biquad_filter_bank_unit_assert.svh
`include "bandpass_biquad_filter_bank_unit_assert.svh"

module bbf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [bbf_pkg::NUM_BANDS_BITS-1:0] cfg_data,
    input logic                               s_valid,
    input logic                               s_ready,
    input bbf_pkg::in_item_t                  s_item,
    input logic                               m_valid,
    input logic                               m_ready,
    input bbf_pkg::out_item_t                 m_item
);

    logic sample_fire;
    logic coef_fire;

    assign sample_fire = s_valid && s_ready && (s_item.operation == bbf_pkg::OP_SAMPLE);
    assign coef_fire   = s_valid && s_ready && (s_item.operation == bbf_pkg::OP_COEF_WRITE);

    // a stalled result holds
    `BBF_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // no new request while a sample still has bands to deliver
    `BBF_ASSERT_SAME(a_no_accept_mid_sample, aclk, aresetn, m_valid && !m_item.last, !s_ready)

    // a sample request keeps the input closed for at least the next cycle
    `BBF_ASSERT_NEXT(a_sample_busy, aclk, aresetn, sample_fire, !s_ready)

    // a coefficient request yields no result
    `BBF_ASSERT_NEXT(a_coef_silent, aclk, aresetn, coef_fire && !m_valid, !m_valid)

endmodule

bind bandpass_biquad_filter_bank_unit bbf_checker u_bbf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_item    (s_item),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item)
);
